@@ rtl/rih_pkg.sv @@
`timescale 1ns / 1ps
package rih_pkg;
	localparam int BUCKETS_DEF = 1024;
	localparam int ENTRIES_DEF = 512;
	localparam int KEY_BYTES = 8;
	localparam logic [31:0] FNV_BASIS = 32'h811c9dc5;
	localparam logic [31:0] FNV_PRIME = 32'h01000193;
	localparam logic [31:0] RC_MAX = 32'hffffffff;

	localparam logic [2:0] OP_INTERN  = 3'd0;
	localparam logic [2:0] OP_FIND    = 3'd1;
	localparam logic [2:0] OP_ADDREF  = 3'd2;
	localparam logic [2:0] OP_RELEASE = 3'd3;
	localparam logic [2:0] OP_GET     = 3'd4;

	localparam logic [2:0] ST_CREATED  = 3'd0;
	localparam logic [2:0] ST_DONE     = 3'd1;
	localparam logic [2:0] ST_NOTFOUND = 3'd2;
	localparam logic [2:0] ST_FULL     = 3'd3;
	localparam logic [2:0] ST_BADID    = 3'd4;

	// datapath commands
	typedef struct packed {
		logic clr;         // zero one bucket of the table after reset
		logic load;        // capture request, start hash
		logic hash_step;   // fold one key byte
		logic bkt_rd;      // read bucket at probe pointer
		logic ent_rd;      // read entry at id from bucket (or target)
		logic ent_rd_tgt;  // entry read uses target id
		logic probe_adv;   // advance probe pointer
		logic alloc;       // allocate new entry into probe bucket
		logic rc_write;    // write refcount (inc or dec per op)
		logic free_entry;  // clear live, push id, clear bucket at probe pointer
		logic gap_set;     // gap = probe pointer
		logic shift_move;  // move bucket entry into gap, clear probe bucket
		logic res_set;     // latch result
	} rih_cmd_t;

	typedef struct packed {
		logic clr_done;
		logic hash_done;
		logic bkt_empty;
		logic bkt_hit_id;   // bucket holds target id
		logic key_match;
		logic wrapped;      // probed all buckets
		logic id_ok;
		logic can_alloc;
		logic rc_le1;
		logic must_move;
		logic [2:0] op;
	} rih_sts_t;
endpackage

@@ rtl/rih_datapath.sv @@
`timescale 1ns / 1ps
module rih_datapath import rih_pkg::*; #(
	parameter int BUCKETS = BUCKETS_DEF,
	parameter int ENTRIES = ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  rih_cmd_t    cmd,
	output rih_sts_t    sts,
	input  logic [2:0]  op,
	input  logic [63:0] key_bytes,
	input  logic [3:0]  key_length,
	input  logic [9:0]  target_id,
	output logic [9:0]  result_id,
	output logic [2:0]  status,
	output logic [31:0] ref_count,
	output logic [63:0] stored_key,
	output logic [3:0]  stored_length,
	output logic [9:0]  live_entries
);
	localparam int BW = $clog2(BUCKETS);
	localparam int EW = $clog2(ENTRIES);
	localparam int IW = $clog2(ENTRIES + 1);

	logic [IW-1:0] bucket_mem [BUCKETS];
	logic [63:0]   key_mem    [ENTRIES];
	logic [3:0]    len_mem    [ENTRIES];
	logic [BW-1:0] home_mem   [ENTRIES];
	logic [31:0]   hash_mem   [ENTRIES];
	logic [31:0]   rc_mem     [ENTRIES];
	logic [IW-1:0] free_mem   [ENTRIES];
	logic [ENTRIES-1:0] live_q;

	logic [2:0]    op_q;
	logic [63:0]   key_q;
	logic [3:0]    len_q;
	logic [IW-1:0] tid_q;
	logic          rng_ok_q;
	logic          tok_q;
	logic [31:0]   hash_q;
	logic [3:0]    hcnt_q;
	logic [BW-1:0] ptr_q, gap_q;
	logic [BW:0]   probes_q;
	logic [BW:0]   clr_q;
	logic [IW-1:0] bkt_q;
	logic [63:0]   ekey_q;
	logic [3:0]    elen_q;
	logic [31:0]   ehash_q, erc_q;
	logic [BW-1:0] ehome_q;
	logic [IW-1:0] eid_q;
	logic [IW:0]   ftop_q;
	logic [IW:0]   fresh_q;
	logic [IW-1:0] live_cnt_q;
	logic [IW-1:0] pop_id_q;
	logic          tid_ok;
	logic [3:0]    len_sat;
	logic [63:0]   key_mask;
	logic [7:0]    hbyte;
	logic [31:0]   rc_new;
	logic [IW-1:0] new_id;
	logic [IW-1:0] tid_trunc;

	assign len_sat = (key_length > 4'(KEY_BYTES)) ? 4'(KEY_BYTES) : key_length;
	always_comb begin
		key_mask = '0;
		for (int b = 0; b < 8; b++)
			if (4'(b) < len_sat) key_mask[8*b +: 8] = 8'hff;
	end
	assign tid_trunc = IW'(target_id);
	assign tid_ok = rng_ok_q && live_q[EW'(tid_q - 1'b1)];
	assign hbyte = key_q[{hcnt_q[2:0], 3'b000} +: 8];
	assign new_id = (ftop_q != '0) ? pop_id_q : fresh_q[IW-1:0];

	always_comb begin
		if (op_q == OP_RELEASE) rc_new = erc_q - 32'd1;
		else if (erc_q == RC_MAX) rc_new = erc_q;
		else rc_new = erc_q + 32'd1;
	end

	always_comb begin
		logic [BW-1:0] home;
		home = ehome_q;
		sts.clr_done   = (clr_q == (BW+1)'(BUCKETS));
		sts.hash_done  = (hcnt_q == len_q);
		sts.bkt_empty  = (bkt_q == '0);
		sts.bkt_hit_id = (bkt_q == tid_q);
		sts.key_match  = (ehash_q == hash_q) && (elen_q == len_q) && (ekey_q == key_q);
		sts.wrapped    = (probes_q == (BW+1)'(BUCKETS));
		sts.id_ok      = tid_ok;
		sts.can_alloc  = (ftop_q != '0) || (fresh_q <= (IW+1)'(ENTRIES));
		sts.rc_le1     = (erc_q <= 32'd1);
		if (home <= ptr_q) sts.must_move = (home <= gap_q) && (gap_q < ptr_q);
		else sts.must_move = (home <= gap_q) || (gap_q < ptr_q);
		sts.op = op_q;
	end

	// request capture and hash
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= op;
			key_q    <= key_bytes & key_mask;
			len_q    <= len_sat;
			tid_q    <= tid_trunc;
			rng_ok_q <= (target_id != '0) && ({22'd0, target_id} <= ENTRIES);
			hash_q   <= FNV_BASIS;
			hcnt_q   <= '0;
		end else if (cmd.hash_step) begin
			hash_q <= (hash_q ^ {24'd0, hbyte}) * FNV_PRIME;
			hcnt_q <= hcnt_q + 4'd1;
		end
	end

	// hold the target check, the entry may be freed before the result
	always_ff @(posedge clk) begin
		if (cmd.load) tok_q <= 1'b0;
		else if (cmd.ent_rd_tgt) tok_q <= 1'b1;
	end

	// probe pointer
	always_ff @(posedge clk) begin
		if (cmd.hash_step && (hcnt_q + 4'd1 == len_q)) begin
			ptr_q    <= BW'((hash_q ^ {24'd0, hbyte}) * FNV_PRIME);
			probes_q <= '0;
		end else if (cmd.load) begin
			ptr_q    <= BW'(FNV_BASIS);
			probes_q <= '0;
		end else if (cmd.ent_rd_tgt) begin
			ptr_q    <= home_mem[EW'(tid_q - 1'b1)];
			probes_q <= '0;
		end else if (cmd.probe_adv) begin
			ptr_q    <= ptr_q + 1'b1;
			probes_q <= probes_q + 1'b1;
		end
		if (cmd.gap_set) gap_q <= ptr_q;
		else if (cmd.shift_move) gap_q <= ptr_q;
	end

	// bucket memory
	always_ff @(posedge clk) begin
		if (cmd.bkt_rd) bkt_q <= bucket_mem[ptr_q];
		if (cmd.clr) bucket_mem[BW'(clr_q)] <= '0;
		else if (cmd.alloc) bucket_mem[ptr_q] <= new_id;
		else if (cmd.free_entry) bucket_mem[ptr_q] <= '0;
		else if (cmd.shift_move) begin
			bucket_mem[gap_q] <= bkt_q;
			bucket_mem[ptr_q] <= '0;
		end
	end

	// entry memories
	always_ff @(posedge clk) begin
		if (cmd.ent_rd) begin
			eid_q   <= cmd.ent_rd_tgt ? tid_q : bkt_q;
			ekey_q  <= key_mem[EW'((cmd.ent_rd_tgt ? tid_q : bkt_q) - 1'b1)];
			elen_q  <= len_mem[EW'((cmd.ent_rd_tgt ? tid_q : bkt_q) - 1'b1)];
			ehash_q <= hash_mem[EW'((cmd.ent_rd_tgt ? tid_q : bkt_q) - 1'b1)];
			ehome_q <= home_mem[EW'((cmd.ent_rd_tgt ? tid_q : bkt_q) - 1'b1)];
			erc_q   <= rc_mem[EW'((cmd.ent_rd_tgt ? tid_q : bkt_q) - 1'b1)];
		end
		if (cmd.alloc) begin
			key_mem[EW'(new_id - 1'b1)]  <= key_q;
			len_mem[EW'(new_id - 1'b1)]  <= len_q;
			hash_mem[EW'(new_id - 1'b1)] <= hash_q;
			home_mem[EW'(new_id - 1'b1)] <= BW'(hash_q);
			rc_mem[EW'(new_id - 1'b1)]   <= 32'd1;
		end else if (cmd.rc_write) begin
			rc_mem[EW'(eid_q - 1'b1)] <= rc_new;
		end
		if (cmd.free_entry) free_mem[EW'(ftop_q[IW-1:0])] <= tid_q;
		pop_id_q <= free_mem[EW'(ftop_q[IW-1:0] - 1'b1)];
	end

	// allocator and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q     <= '0;
			ftop_q     <= '0;
			fresh_q    <= (IW+1)'(1);
			live_cnt_q <= '0;
			clr_q      <= '0;
		end else begin
			if (cmd.clr) clr_q <= clr_q + 1'b1;
			if (cmd.alloc) begin
				live_q[EW'(new_id - 1'b1)] <= 1'b1;
				live_cnt_q <= live_cnt_q + 1'b1;
				if (ftop_q != '0) ftop_q <= ftop_q - 1'b1;
				else fresh_q <= fresh_q + 1'b1;
			end else if (cmd.free_entry) begin
				live_q[EW'(tid_q - 1'b1)] <= 1'b0;
				live_cnt_q <= live_cnt_q - 1'b1;
				ftop_q <= ftop_q + 1'b1;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.res_set) begin
			result_id     <= '0;
			status        <= ST_BADID;
			ref_count     <= '0;
			stored_key    <= '0;
			stored_length <= '0;
			live_entries  <= 10'(live_cnt_q);
			unique case (op_q)
				OP_INTERN, OP_FIND: begin
					if (cmd.alloc) begin
						result_id    <= 10'(new_id);
						status       <= ST_CREATED;
						ref_count    <= 32'd1;
						live_entries <= 10'(live_cnt_q + 1'b1);
					end else if (!sts.bkt_empty && sts.key_match && !sts.wrapped) begin
						result_id <= 10'(eid_q);
						status    <= ST_DONE;
						ref_count <= (op_q == OP_INTERN) ? rc_new : erc_q;
					end else begin
						status <= (op_q == OP_INTERN) ? ST_FULL : ST_NOTFOUND;
					end
				end
				OP_ADDREF, OP_RELEASE, OP_GET: begin
					if (tok_q) begin
						result_id <= 10'(tid_q);
						status    <= ST_DONE;
						if (op_q == OP_GET) begin
							ref_count     <= erc_q;
							stored_key    <= ekey_q;
							stored_length <= elen_q;
						end else if (op_q == OP_RELEASE && !cmd.rc_write) begin
							ref_count <= '0;
						end else begin
							ref_count <= rc_new;
						end
					end
				end
				default: ;
			endcase
		end
	end
endmodule

@@ rtl/rih_ctrl.sv @@
`timescale 1ns / 1ps
module rih_ctrl import rih_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  rih_sts_t sts,
	output rih_cmd_t cmd
);
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_HASH  = 4'd1;
	localparam logic [3:0] S_BRD   = 4'd2;
	localparam logic [3:0] S_ERD   = 4'd3;
	localparam logic [3:0] S_CHK   = 4'd4;
	localparam logic [3:0] S_TRD   = 4'd5;
	localparam logic [3:0] S_TCHK  = 4'd6;
	localparam logic [3:0] S_UBRD  = 4'd7;
	localparam logic [3:0] S_UCHK  = 4'd8;
	localparam logic [3:0] S_SBRD  = 4'd9;
	localparam logic [3:0] S_SERD  = 4'd10;
	localparam logic [3:0] S_SCHK  = 4'd11;
	localparam logic [3:0] S_OUT   = 4'd12;
	localparam logic [3:0] S_FIN   = 4'd13;
	localparam logic [3:0] S_CLR   = 4'd14;

	logic [3:0] state_q, state_d;
	logic       ok_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);

	always_comb begin
		cmd = '0;
		state_d = state_q;
		unique case (state_q)
			// zero the bucket table once after reset
			S_CLR: begin
				if (sts.clr_done) state_d = S_IDLE;
				else cmd.clr = 1'b1;
			end
			S_IDLE: if (in_valid) begin
				cmd.load = 1'b1;
				state_d = S_HASH;
			end
			S_HASH: begin
				if (sts.op == OP_INTERN || sts.op == OP_FIND) begin
					if (sts.hash_done) state_d = S_BRD;
					else cmd.hash_step = 1'b1;
				end else begin
					state_d = S_TRD;
				end
			end
			S_BRD: begin
				cmd.bkt_rd = 1'b1;
				state_d = S_ERD;
			end
			S_ERD: begin
				cmd.ent_rd = 1'b1;
				state_d = S_CHK;
			end
			S_CHK: begin
				// empty bucket, match, or table exhausted ends the probe
				if (sts.wrapped) begin
					cmd.res_set = 1'b1;
					state_d = S_OUT;
				end else if (sts.bkt_empty) begin
					cmd.res_set = 1'b1;
					if (sts.op == OP_INTERN && sts.can_alloc) cmd.alloc = 1'b1;
					state_d = S_OUT;
				end else if (sts.key_match) begin
					cmd.res_set = 1'b1;
					if (sts.op == OP_INTERN) cmd.rc_write = 1'b1;
					state_d = S_OUT;
				end else begin
					cmd.probe_adv = 1'b1;
					state_d = S_BRD;
				end
			end
			S_TRD: begin
				cmd.ent_rd = 1'b1;
				cmd.ent_rd_tgt = sts.id_ok;
				state_d = S_TCHK;
			end
			S_TCHK: begin
				cmd.res_set = 1'b1;
				state_d = S_OUT;
				if (ok_q && (sts.op == OP_ADDREF ||
						(sts.op == OP_RELEASE && !sts.rc_le1))) begin
					cmd.rc_write = 1'b1;
				end else if (ok_q && sts.op == OP_RELEASE) begin
					cmd.res_set = 1'b0;
					state_d = S_UBRD;
				end
			end
			// locate the released id along its probe run
			S_UBRD: begin
				cmd.bkt_rd = 1'b1;
				state_d = S_UCHK;
			end
			S_UCHK: begin
				if (sts.bkt_empty || sts.wrapped) begin
					state_d = S_FIN;
				end else if (sts.bkt_hit_id) begin
					cmd.free_entry = 1'b1;
					cmd.gap_set = 1'b1;
					cmd.probe_adv = 1'b1;
					state_d = S_SBRD;
				end else begin
					cmd.probe_adv = 1'b1;
					state_d = S_UBRD;
				end
			end
			// backward shift of the cluster after the gap
			S_SBRD: begin
				cmd.bkt_rd = 1'b1;
				state_d = S_SERD;
			end
			S_SERD: begin
				cmd.ent_rd = 1'b1;
				state_d = S_SCHK;
			end
			S_SCHK: begin
				if (sts.bkt_empty || sts.wrapped) begin
					state_d = S_FIN;
				end else begin
					if (sts.must_move) cmd.shift_move = 1'b1;
					cmd.probe_adv = 1'b1;
					state_d = S_SBRD;
				end
			end
			S_FIN: begin
				cmd.res_set = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: if (out_ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			ok_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_TRD) ok_q <= sts.id_ok;
		end
	end
endmodule

@@ rtl/refcounted_intern_hash_table_core.sv @@
`timescale 1ns / 1ps
// Intern/find hash the key byte by byte, then read bucket and entry per probed bucket;
// addref/get read the target entry; a last release also finds the id along its probe run
// and shifts back the entries behind it. One request at a time; the bucket memory port
// sets the pace. Reset clears live flags, allocator and counters at once; then the bucket
// table is zeroed one bucket a cycle, with in_ready low.
module refcounted_intern_hash_table_core import rih_pkg::*; #(
	parameter int BUCKETS = BUCKETS_DEF,
	parameter int ENTRIES = ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  op,
	input  logic [63:0] key_bytes,
	input  logic [3:0]  key_length,
	input  logic [9:0]  target_id,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [9:0]  result_id,
	output logic [2:0]  status,
	output logic [31:0] ref_count,
	output logic [63:0] stored_key,
	output logic [3:0]  stored_length,
	output logic [9:0]  live_entries
);
	rih_cmd_t cmd;
	rih_sts_t sts;

	rih_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready, .sts, .cmd
	);

	rih_datapath #(.BUCKETS(BUCKETS), .ENTRIES(ENTRIES)) u_dp (
		.clk, .arst_n, .cmd, .sts, .op, .key_bytes, .key_length, .target_id,
		.result_id, .status, .ref_count, .stored_key, .stored_length, .live_entries
	);
endmodule

@@ dv/tb_refcounted_intern_hash_table_core.sv @@
`timescale 1ns / 1ps
module tb_refcounted_intern_hash_table_core;
	import rih_pkg::*;

	localparam int NB = BUCKETS_DEF;
	localparam int NE = ENTRIES_DEF;
	localparam logic [2:0] OP_BAD5 = 3'd5;
	localparam logic [2:0] OP_BAD6 = 3'd6;
	localparam logic [2:0] OP_BAD7 = 3'd7;

	typedef struct packed {
		logic [9:0]  rid;
		logic [2:0]  st;
		logic [31:0] rc;
		logic [63:0] skey;
		logic [3:0]  slen;
		logic [9:0]  live;
	} lookup_result_t;

	typedef struct {
		logic [2:0]     op;
		logic [63:0]    key;
		logic [3:0]     len;
		logic [9:0]     tid;
		bit             typed;
		lookup_result_t res;
	} request_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	logic [2:0] op;
	logic [63:0] key_bytes;
	logic [3:0] key_length;
	logic [9:0] target_id;
	logic [9:0] result_id;
	logic [2:0] status;
	logic [31:0] ref_count;
	logic [63:0] stored_key;
	logic [3:0] stored_length;
	logic [9:0] live_entries;

	refcounted_intern_hash_table_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.op(op), .key_bytes(key_bytes), .key_length(key_length), .target_id(target_id),
		.out_valid(out_valid), .out_ready(out_ready),
		.result_id(result_id), .status(status), .ref_count(ref_count),
		.stored_key(stored_key), .stored_length(stored_length), .live_entries(live_entries)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// shadow table
	int unsigned bucket_id[NB];
	logic [63:0] ent_key[NE];
	logic [3:0]  ent_len[NE];
	logic [31:0] ent_hash[NE];
	logic [31:0] ent_rc[NE];
	bit          ent_live[NE];
	int unsigned free_stack[NE];
	int unsigned free_top;
	int unsigned fresh_id;
	int unsigned live_cnt;

	lookup_result_t pending_results[$];
	int unsigned mismatches;
	logic [63:0] key_pool[48];

	function automatic logic [31:0] fnv1a(logic [63:0] k, int unsigned n);
		logic [31:0] h;
		h = FNV_BASIS;
		for (int i = 0; i < n; i++) begin
			h = (h ^ {24'd0, k[8*i +: 8]}) * FNV_PRIME;
		end
		return h;
	endfunction

	function automatic bit shifts_into_gap(int unsigned home, int unsigned gap, int unsigned cur);
		if (home <= cur)
			return home <= gap && gap < cur;
		return home <= gap || gap < cur;
	endfunction

	function automatic void unlink_entry(int unsigned id);
		int unsigned slot, gap, e, i;
		bit hit;
		hit = 0;
		slot = ent_hash[id-1] % NB;
		for (i = 0; i < NB; i++) begin
			if (bucket_id[slot] == 0)
				return;
			if (bucket_id[slot] == id) begin
				hit = 1;
				break;
			end
			slot = (slot + 1) % NB;
		end
		if (!hit)
			return;
		bucket_id[slot] = 0;
		gap = slot;
		slot = (slot + 1) % NB;
		for (i = 0; i < NB; i++) begin
			e = bucket_id[slot];
			if (e == 0)
				break;
			if (shifts_into_gap(ent_hash[e-1] % NB, gap, slot)) begin
				bucket_id[gap] = e;
				bucket_id[slot] = 0;
				gap = slot;
			end
			slot = (slot + 1) % NB;
		end
	endfunction

	function automatic lookup_result_t apply_request(logic [2:0] o, logic [63:0] k_in,
			logic [3:0] l_in, logic [9:0] tid);
		lookup_result_t r;
		int unsigned n, slot, e, nid;
		logic [63:0] k;
		logic [31:0] h;
		r = '0;
		r.st = ST_BADID;
		n = (l_in > KEY_BYTES) ? KEY_BYTES : l_in;
		k = (n >= 8) ? k_in : (k_in & ((64'd1 << (8*n)) - 64'd1));
		h = fnv1a(k, n);
		if (o == OP_INTERN || o == OP_FIND) begin
			r.st = (o == OP_INTERN) ? ST_FULL : ST_NOTFOUND;
			slot = h % NB;
			for (int i = 0; i < NB; i++) begin
				e = bucket_id[slot];
				if (e == 0) begin
					if (o == OP_FIND)
						break;
					if (free_top > 0) begin
						free_top--;
						nid = free_stack[free_top];
					end else if (fresh_id <= NE) begin
						nid = fresh_id;
						fresh_id++;
					end else begin
						break;
					end
					ent_key[nid-1] = k;
					ent_len[nid-1] = 4'(n);
					ent_hash[nid-1] = h;
					ent_rc[nid-1] = 32'd1;
					ent_live[nid-1] = 1;
					bucket_id[slot] = nid;
					live_cnt++;
					r.rid = 10'(nid);
					r.rc = 32'd1;
					r.st = ST_CREATED;
					break;
				end
				if (ent_hash[e-1] == h && ent_len[e-1] == n && ent_key[e-1] == k) begin
					if (o == OP_INTERN && ent_rc[e-1] != RC_MAX)
						ent_rc[e-1]++;
					r.rid = 10'(e);
					r.rc = ent_rc[e-1];
					r.st = ST_DONE;
					break;
				end
				slot = (slot + 1) % NB;
			end
		end else if ((o == OP_ADDREF || o == OP_RELEASE || o == OP_GET) &&
				tid >= 1 && tid <= NE && ent_live[tid-1]) begin
			r.rid = tid;
			r.st = ST_DONE;
			if (o == OP_ADDREF) begin
				if (ent_rc[tid-1] != RC_MAX)
					ent_rc[tid-1]++;
				r.rc = ent_rc[tid-1];
			end else if (o == OP_RELEASE) begin
				if (ent_rc[tid-1] <= 1) begin
					unlink_entry(tid);
					ent_live[tid-1] = 0;
					ent_rc[tid-1] = '0;
					free_stack[free_top] = tid;
					free_top++;
					live_cnt--;
				end else begin
					ent_rc[tid-1]--;
					r.rc = ent_rc[tid-1];
				end
			end else begin
				r.rc = ent_rc[tid-1];
				r.skey = ent_key[tid-1];
				r.slen = ent_len[tid-1];
			end
		end
		r.live = 10'(live_cnt);
		return r;
	endfunction

	task automatic send_request(logic [2:0] o, logic [63:0] k, logic [3:0] l, logic [9:0] tid,
			bit typed = 0, lookup_result_t typed_res = '0);
		lookup_result_t r;
		int unsigned gap;
		in_valid <= 1'b1;
		op <= o;
		key_bytes <= k;
		key_length <= l;
		target_id <= tid;
		do @(posedge clk); while (!in_ready);
		r = apply_request(o, k, l, tid);
		pending_results.push_back(typed ? typed_res : r);
		gap = $urandom_range(0, 3);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic logic [9:0] pick_live_id();
		int unsigned id;
		for (int t = 0; t < 16; t++) begin
			id = $urandom_range(1, NE);
			if (ent_live[id-1])
				return 10'(id);
		end
		for (int i = 0; i < NE; i++) begin
			if (ent_live[i])
				return 10'(i + 1);
		end
		return 10'($urandom_range(0, 1023));
	endfunction

	task automatic random_mix(int unsigned count, int unsigned release_weight);
		int unsigned sel;
		logic [63:0] k;
		for (int i = 0; i < count; i++) begin
			sel = $urandom_range(0, 99);
			k = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : key_pool[$urandom_range(0, 47)];
			if (sel < 35)
				send_request(OP_INTERN, k, 4'($urandom_range(0, 15)),
					10'($urandom_range(0, 1023)));
			else if (sel < 50)
				send_request(OP_FIND, k, 4'($urandom_range(0, 15)),
					10'($urandom_range(0, 1023)));
			else if (sel < 60)
				send_request(OP_ADDREF, k, 4'($urandom_range(0, 15)), pick_live_id());
			else if (sel < 60 + release_weight)
				send_request(OP_RELEASE, k, 4'($urandom_range(0, 15)), pick_live_id());
			else if (sel < 95)
				send_request(OP_GET, k, 4'($urandom_range(0, 15)), pick_live_id());
			else if (sel < 98)
				send_request(3'($urandom_range(OP_ADDREF, OP_GET)), k,
					4'($urandom_range(0, 15)), 10'($urandom_range(0, 1023)));
			else
				send_request(3'($urandom_range(OP_BAD5, OP_BAD7)), k,
					4'($urandom_range(0, 15)), 10'($urandom_range(0, 1023)));
		end
	endtask

	// receive side: random stalls, compare in order
	initial begin
		lookup_result_t want, got;
		int unsigned stall;
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = $urandom_range(0, 3);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			got = '{result_id, status, ref_count, stored_key, stored_length, live_entries};
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected transfer: %p", got);
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p, got %p", want, got);
				end
			end
		end
	end

	initial begin
		#20ms;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		request_row_t rows[$];
		mismatches = 0;
		foreach (bucket_id[i]) bucket_id[i] = 0;
		foreach (ent_live[i]) ent_live[i] = 0;
		free_top = 0;
		fresh_id = 1;
		live_cnt = 0;
		foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};

		arst_n <= 1'b0;
		in_valid <= 1'b0;
		op <= OP_INTERN;
		key_bytes <= '0;
		key_length <= '0;
		target_id <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		rows = '{
			'{OP_FIND, 64'h1234, 4'd2, 10'd0, 1, '{10'd0, ST_NOTFOUND, 32'd0, 64'd0, 4'd0, 10'd0}},
			'{OP_GET, 64'd0, 4'd0, 10'd0, 1, '{10'd0, ST_BADID, 32'd0, 64'd0, 4'd0, 10'd0}},
			'{OP_RELEASE, 64'd0, 4'd0, 10'd513, 1, '{10'd0, ST_BADID, 32'd0, 64'd0, 4'd0, 10'd0}},
			'{OP_ADDREF, 64'd0, 4'd0, 10'd1023, 1, '{10'd0, ST_BADID, 32'd0, 64'd0, 4'd0, 10'd0}},
			'{OP_BAD5, 64'd0, 4'd0, 10'd1, 1, '{10'd0, ST_BADID, 32'd0, 64'd0, 4'd0, 10'd0}},
			'{OP_BAD6, 64'd0, 4'd8, 10'd1, 1, '{10'd0, ST_BADID, 32'd0, 64'd0, 4'd0, 10'd0}},
			'{OP_BAD7, '1, 4'd15, 10'd1023, 1, '{10'd0, ST_BADID, 32'd0, 64'd0, 4'd0, 10'd0}},
			'{OP_INTERN, '1, 4'd8, 10'd0, 1, '{10'd1, ST_CREATED, 32'd1, 64'd0, 4'd0, 10'd1}},
			// length above the maximum saturates onto the same key
			'{OP_INTERN, '1, 4'd15, 10'd0, 1, '{10'd1, ST_DONE, 32'd2, 64'd0, 4'd0, 10'd1}},
			'{OP_INTERN, '1, 4'd0, 10'd0, 1, '{10'd2, ST_CREATED, 32'd1, 64'd0, 4'd0, 10'd2}},
			'{OP_INTERN, '1, 4'd3, 10'd0, 0, '0},
			'{OP_FIND, 64'h0000_0000_00ff_ffff, 4'd3, 10'd0, 0, '0},
			'{OP_GET, 64'd0, 4'd0, 10'd3, 0, '0},
			'{OP_GET, 64'd0, 4'd0, 10'd1, 0, '0},
			'{OP_ADDREF, 64'd0, 4'd0, 10'd1, 0, '0},
			'{OP_RELEASE, 64'd0, 4'd0, 10'd1, 0, '0},
			'{OP_RELEASE, 64'd0, 4'd0, 10'd1, 0, '0},
			'{OP_RELEASE, 64'd0, 4'd0, 10'd1, 0, '0},
			'{OP_GET, 64'd0, 4'd0, 10'd1, 0, '0},
			'{OP_FIND, '1, 4'd8, 10'd0, 0, '0},
			'{OP_INTERN, 64'h5a5a_a5a5_0f0f_f0f0, 4'd8, 10'd0, 0, '0},
			'{OP_RELEASE, 64'd0, 4'd0, 10'd2, 0, '0},
			'{OP_GET, 64'd0, 4'd0, 10'd512, 0, '0}
		};
		foreach (rows[i])
			send_request(rows[i].op, rows[i].key, rows[i].len, rows[i].tid, rows[i].typed,
				rows[i].res);

		random_mix(300, 20);

		// drain before filling the table
		in_valid <= 1'b0;
		wait (pending_results.size() == 0);
		@(posedge clk);

		// fill past capacity to reach table full
		for (int i = 0; i < 520; i++)
			send_request(OP_INTERN, {$urandom, $urandom}, 4'd8, 10'($urandom_range(0, 1023)));

		random_mix(300, 30);

		in_valid <= 1'b0;
		wait (pending_results.size() == 0);
		repeat (100) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
